/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/dbnfb_pkg.sv */
// Package: geometry constants, beat types, microcode word and control ROM.
`timescale 1ns / 1ps
`default_nettype none

package dbnfb_pkg;

    localparam int ROW_BYTES = 12;
    localparam int ROWS      = 7;
    localparam int COLS      = 2 * ROW_BYTES;
    localparam int BUF_BYTES = ROW_BYTES * ROWS;
    localparam int STORE_BYTES = 2 * BUF_BYTES;
    localparam int ADDR_W    = $clog2(STORE_BYTES);
    localparam int CB_W      = 4;     // byte column taken from x_pos[4:1]

    typedef enum logic [2:0] {
        OP_PUT        = 3'd0,
        OP_GET        = 3'd1,
        OP_FILL       = 3'd2,
        OP_SWAP       = 3'd3,
        OP_READ_SHOWN = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] x_pos;
        logic [2:0] y_pos;
        logic [4:0] rect_width;
        logic [2:0] rect_height;
        logic [3:0] color;
    } cmd_t;

    typedef struct packed {
        logic [3:0] pixel_value;
        logic       front_buffer;
        logic       out_of_range;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUT_RD,
        S_PUT_WR,
        S_GET_RD,
        S_GET_CAP,
        S_FILL_INIT,
        S_FILL_RD,
        S_FILL_WR,
        S_SWAP,
        S_CLR,
        S_INIT_CLR,
        S_DONE
    } step_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_START,
        COND_OFF_PIX,
        COND_FILL_SKIP,
        COND_FILL_LAST,
        COND_CLR_LAST
    } cond_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_OFFCHK,
        ACT_CAPTURE,
        ACT_FILL_INIT,
        ACT_FILL_ADV,
        ACT_SWAP,
        ACT_CLR_ADV
    } act_t;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_PIX,
        WD_FILL
    } wd_t;

    typedef enum logic [1:0] {
        ADDR_PIX,
        ADDR_FILL,
        ADDR_LIN
    } asel_t;

    typedef struct packed {
        logic  idle;
        logic  strobe;
        logic  rd;
        logic  wr;
        wd_t   wd;
        asel_t asel;
        act_t  act;
        cond_t cond;
        step_t nxt;
        step_t jmp;
    } ctrl_t;

    typedef struct packed {
        logic off_pix;
        logic fill_skip;
        logic fill_last;
        logic clr_last;
    } status_t;

    function automatic ctrl_t ctrl_rom(input step_t s);
        ctrl_t w;
        w = '{idle: 1'b0, strobe: 1'b0, rd: 1'b0, wr: 1'b0, wd: WD_ZERO,
              asel: ADDR_PIX, act: ACT_NONE, cond: COND_NONE,
              nxt: S_IDLE, jmp: S_IDLE};
        case (s)
            S_IDLE:
            begin
                w.idle = 1'b1;
                w.cond = COND_START;
            end
            S_PUT_RD:
            begin
                w.rd   = 1'b1;
                w.act  = ACT_OFFCHK;
                w.cond = COND_OFF_PIX;
                w.nxt  = S_PUT_WR;
                w.jmp  = S_DONE;
            end
            S_PUT_WR:
            begin
                w.wr  = 1'b1;
                w.wd  = WD_PIX;
                w.nxt = S_DONE;
            end
            S_GET_RD:
            begin
                w.rd   = 1'b1;
                w.act  = ACT_OFFCHK;
                w.cond = COND_OFF_PIX;
                w.nxt  = S_GET_CAP;
                w.jmp  = S_DONE;
            end
            S_GET_CAP:
            begin
                w.act = ACT_CAPTURE;
                w.nxt = S_DONE;
            end
            S_FILL_INIT:
            begin
                w.act  = ACT_FILL_INIT;
                w.cond = COND_FILL_SKIP;
                w.nxt  = S_FILL_RD;
                w.jmp  = S_DONE;
            end
            S_FILL_RD:
            begin
                w.rd   = 1'b1;
                w.asel = ADDR_FILL;
                w.nxt  = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                w.wr   = 1'b1;
                w.wd   = WD_FILL;
                w.asel = ADDR_FILL;
                w.act  = ACT_FILL_ADV;
                w.cond = COND_FILL_LAST;
                w.nxt  = S_FILL_RD;
                w.jmp  = S_DONE;
            end
            S_SWAP:
            begin
                w.act = ACT_SWAP;
                w.nxt = S_CLR;
            end
            S_CLR:
            begin
                w.wr   = 1'b1;
                w.asel = ADDR_LIN;
                w.act  = ACT_CLR_ADV;
                w.cond = COND_CLR_LAST;
                w.nxt  = S_CLR;
                w.jmp  = S_DONE;
            end
            S_INIT_CLR:
            begin
                w.wr   = 1'b1;
                w.asel = ADDR_LIN;
                w.act  = ACT_CLR_ADV;
                w.cond = COND_CLR_LAST;
                w.nxt  = S_INIT_CLR;
                w.jmp  = S_IDLE;
            end
            S_DONE:
            begin
                w.strobe = 1'b1;
                w.nxt    = S_IDLE;
            end
            default:
            begin
                w.idle = 1'b1;
                w.cond = COND_START;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/double_buffered_nibble_framebuffer.sv */
// Top level: double-buffered 24x7 framebuffer, 4 bits per pixel, microcoded.
// Accepted beat to done: put and get read the byte, then write or capture it
//   (off display they go straight to done); an unused op goes to done; fill
//   reads and writes each touched byte; swap clears the new back buffer.
// Reset: asynchronous, rst_n low; then a clearing pass holds busy high.
// Results cannot be stalled: done lasts one cycle. Beats are taken only in idle.
`timescale 1ns / 1ps
`default_nettype none

module double_buffered_nibble_framebuffer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire dbnfb_pkg::cmd_t    cmd,
    output logic                    busy,
    output logic                    done,
    output dbnfb_pkg::result_t      result
);
    import dbnfb_pkg::*;

    ctrl_t   ctrl;
    status_t status;
    logic    accept;

    // The sequencer idles in a single step; everything else counts as busy.
    assign busy   = ~ctrl.idle;
    assign accept = start & ctrl.idle;
    assign done   = ctrl.strobe;

    // Step counter and control ROM. The opcode is dispatched straight from the
    // command beat on the accepting edge.
    dbnfb_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (cmd.op),
        .status (status),
        .ctrl   (ctrl)
    );

    // Operand registers, byte store and result registers. Put read-modifies-writes
    // the addressed byte, get reads it; fill walks bytes row by row with per-nibble
    // enables for the clipped edges; swap zeroes the new back buffer.
    dbnfb_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .cmd    (cmd),
        .ctrl   (ctrl),
        .status (status),
        .result (result)
    );

endmodule

`default_nettype wire

/* rtl/dbnfb_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module dbnfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 168
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/dbnfb_seq.sv */
// Microcode sequencer: step counter, control ROM lookup and jump logic.
`timescale 1ns / 1ps
`default_nettype none

module dbnfb_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2:0]        op,
    input  wire dbnfb_pkg::status_t status,
    output dbnfb_pkg::ctrl_t       ctrl
);
    import dbnfb_pkg::*;

    step_t upc_reg;
    step_t upc_next;
    logic  cond_hit;
    step_t dispatch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_INIT_CLR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // Decode the opcode into the first step of its routine.
    always_comb
    begin
        case (op)
            OP_PUT:        dispatch = S_PUT_RD;
            OP_GET:        dispatch = S_GET_RD;
            OP_READ_SHOWN: dispatch = S_GET_RD;
            OP_FILL:       dispatch = S_FILL_INIT;
            OP_SWAP:       dispatch = S_SWAP;
            default:       dispatch = S_DONE;
        endcase
    end

    // Next step.
    always_comb
    begin
        case (ctrl.cond)
            COND_OFF_PIX:   cond_hit = status.off_pix;
            COND_FILL_SKIP: cond_hit = status.fill_skip;
            COND_FILL_LAST: cond_hit = status.fill_last;
            COND_CLR_LAST:  cond_hit = status.clr_last;
            default:        cond_hit = 1'b0;
        endcase
        if (ctrl.cond == COND_START)
        begin
            upc_next = start ? dispatch : upc_reg;
        end
        else
        begin
            upc_next = cond_hit ? ctrl.jmp : ctrl.nxt;
        end
    end

    // Control word for the current step.
    always_comb
    begin
        ctrl = ctrl_rom(upc_reg);
    end

endmodule

`default_nettype wire

/* rtl/dbnfb_dp.sv */
// Datapath: operand registers, address generation, read-modify-write, result.
`timescale 1ns / 1ps
`default_nettype none

module dbnfb_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire dbnfb_pkg::cmd_t    cmd,
    input  wire dbnfb_pkg::ctrl_t   ctrl,
    output dbnfb_pkg::status_t      status,
    output dbnfb_pkg::result_t      result
);
    import dbnfb_pkg::*;

    logic [2:0]        op_reg;
    logic [4:0]        x_reg;
    logic [2:0]        y_reg;
    logic [4:0]        w_reg;
    logic [2:0]        h_reg;
    logic [3:0]        color_reg;
    logic [3:0]        pix_reg, pix_next;
    logic              oor_reg, oor_next;
    logic              back_reg, back_next;
    logic              shown_reg, shown_next;
    logic [CB_W-1:0]   col_reg, col_next;
    logic [CB_W-1:0]   cbeg_reg, cbeg_next;
    logic [CB_W-1:0]   cend_reg, cend_next;
    logic [2:0]        row_reg, row_next;
    logic [2:0]        rlast_reg, rlast_next;
    logic [4:0]        xe_reg, xe_next;
    logic [ADDR_W-1:0] lin_reg, lin_next;
    logic [ADDR_W-1:0] lend_reg, lend_next;

    logic [5:0]        xe_full;
    logic [3:0]        ye_full;
    logic [4:0]        xe_clip;
    logic [2:0]        ye_clip;
    logic [4:0]        xe_m1;
    logic              pix_buf;
    logic              abuf;
    logic [2:0]        arow;
    logic [CB_W-1:0]   acol;
    logic [ADDR_W-1:0] addr;
    logic [4:0]        lo_col, hi_col;
    logic              lo_en, hi_en;
    logic [7:0]        rdata;
    logic [7:0]        wdata;
    logic [7:0]        or_mask;

    // Operand latch on the accepted beat; working registers update every clock.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg    <= cmd.op;
            x_reg     <= cmd.x_pos;
            y_reg     <= cmd.y_pos;
            w_reg     <= cmd.rect_width;
            h_reg     <= cmd.rect_height;
            color_reg <= cmd.color;
        end
        pix_reg   <= pix_next;
        oor_reg   <= oor_next;
        col_reg   <= col_next;
        cbeg_reg  <= cbeg_next;
        cend_reg  <= cend_next;
        row_reg   <= row_next;
        rlast_reg <= rlast_next;
        xe_reg    <= xe_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_reg  <= 1'b0;
            shown_reg <= 1'b0;
            lin_reg   <= '0;
            lend_reg  <= ADDR_W'(STORE_BYTES - 1);
        end
        else
        begin
            back_reg  <= back_next;
            shown_reg <= shown_next;
            lin_reg   <= lin_next;
            lend_reg  <= lend_next;
        end
    end

    // Rectangle clipping.
    always_comb
    begin
        xe_full = {1'b0, x_reg} + {1'b0, w_reg};
        ye_full = {1'b0, y_reg} + {1'b0, h_reg};
        xe_clip = (xe_full > 6'(COLS)) ? 5'(COLS) : xe_full[4:0];
        ye_clip = (ye_full > 4'(ROWS)) ? 3'(ROWS) : ye_full[2:0];
        xe_m1   = xe_clip - 5'd1;
    end

    always_comb
    begin
        status.off_pix   = (x_reg >= 5'(COLS)) || (y_reg >= 3'(ROWS));
        status.fill_skip = (w_reg == '0) || (h_reg == '0) || status.off_pix;
        status.fill_last = (col_reg == cend_reg) && (row_reg == rlast_reg);
        status.clr_last  = (lin_reg == lend_reg);
    end

    // Address generation.
    always_comb
    begin
        pix_buf = (op_reg == OP_READ_SHOWN) ? shown_reg : back_reg;
        if (ctrl.asel == ADDR_FILL)
        begin
            abuf = back_reg;
            arow = row_reg;
            acol = col_reg;
        end
        else
        begin
            abuf = pix_buf;
            arow = y_reg;
            acol = x_reg[4:1];
        end
        if (ctrl.asel == ADDR_LIN)
        begin
            addr = lin_reg;
        end
        else
        begin
            addr = (abuf ? ADDR_W'(BUF_BYTES) : ADDR_W'(0))
                 + ADDR_W'(arow) * ADDR_W'(ROW_BYTES)
                 + ADDR_W'(acol);
        end
    end

    // Nibble enables for the byte being merged.
    always_comb
    begin
        lo_col = {col_reg, 1'b0};
        hi_col = {col_reg, 1'b1};
        case (ctrl.wd)
            WD_PIX:
            begin
                lo_en = ~x_reg[0];
                hi_en = x_reg[0];
            end
            WD_FILL:
            begin
                lo_en = (lo_col >= x_reg) && (lo_col < xe_reg);
                hi_en = (hi_col >= x_reg) && (hi_col < xe_reg);
            end
            default:
            begin
                lo_en = 1'b0;
                hi_en = 1'b0;
            end
        endcase
        or_mask = {hi_en ? color_reg : 4'd0, lo_en ? color_reg : 4'd0};
        wdata   = (ctrl.wd == WD_ZERO) ? 8'd0 : (rdata | or_mask);
    end

    dbnfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.wr),
        .waddr (addr),
        .wdata (wdata),
        .re    (ctrl.rd),
        .raddr (addr),
        .rdata (rdata)
    );

    // Register updates per microcode action.
    always_comb
    begin
        pix_next   = pix_reg;
        oor_next   = oor_reg;
        back_next  = back_reg;
        shown_next = shown_reg;
        col_next   = col_reg;
        cbeg_next  = cbeg_reg;
        cend_next  = cend_reg;
        row_next   = row_reg;
        rlast_next = rlast_reg;
        xe_next    = xe_reg;
        lin_next   = lin_reg;
        lend_next  = lend_reg;
        if (load)
        begin
            pix_next = '0;
            oor_next = 1'b0;
        end
        case (ctrl.act)
            ACT_OFFCHK:
            begin
                oor_next = status.off_pix;
            end
            ACT_CAPTURE:
            begin
                pix_next = x_reg[0] ? rdata[7:4] : rdata[3:0];
            end
            ACT_FILL_INIT:
            begin
                oor_next   = (w_reg != '0) && (h_reg != '0)
                           && ((xe_full > 6'(COLS)) || (ye_full > 4'(ROWS)));
                col_next   = x_reg[4:1];
                cbeg_next  = x_reg[4:1];
                cend_next  = xe_m1[4:1];
                row_next   = y_reg;
                rlast_next = ye_clip - 3'd1;
                xe_next    = xe_clip;
            end
            ACT_FILL_ADV:
            begin
                if (col_reg == cend_reg)
                begin
                    col_next = cbeg_reg;
                    row_next = row_reg + 3'd1;
                end
                else
                begin
                    col_next = col_reg + CB_W'(1);
                end
            end
            ACT_SWAP:
            begin
                shown_next = back_reg;
                back_next  = ~back_reg;
                lin_next   = back_reg ? ADDR_W'(0) : ADDR_W'(BUF_BYTES);
                lend_next  = back_reg ? ADDR_W'(BUF_BYTES - 1)
                                      : ADDR_W'(STORE_BYTES - 1);
            end
            ACT_CLR_ADV:
            begin
                lin_next = lin_reg + ADDR_W'(1);
            end
            default:
            begin
                pix_next = pix_next;
            end
        endcase
    end

    always_comb
    begin
        result.pixel_value  = pix_reg;
        result.front_buffer = shown_reg;
        result.out_of_range = oor_reg;
    end

endmodule

`default_nettype wire

/* rtl/dbnfb_checker.sv */
// Port-level checker for the framebuffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dbnfb_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire dbnfb_pkg::cmd_t    cmd,
    input wire logic               busy,
    input wire logic               done,
    input wire dbnfb_pkg::result_t result
);
    import dbnfb_pkg::*;

    // A result only appears while an operation is in flight.
    `ASSERT_IMPL(a_done_busy, done, busy)
    // An accepted beat always starts an operation.
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // The block is ready again right after each result.
    `ASSERT_NEXT(a_done_ready, done, !busy)
    // The shown buffer only changes during an operation.
    `ASSERT_NEXT(a_front_hold, !busy, $stable(result.front_buffer))

endmodule

bind double_buffered_nibble_framebuffer dbnfb_checker u_chk (.*);

`default_nettype wire
